FILE: hw/rtl/scpn_pkg.sv
package scpn_pkg;

    localparam int FIX_W   = 32;   // Q16.16 word
    localparam int TOL_W   = 16;
    localparam int PARAM_W = 24;   // Q0.24 result
    localparam int IDX_W   = 4;
    localparam int COEF_N  = 12;
    localparam int AXES    = 3;
    localparam int ROWS    = 4;
    localparam int S_W     = 25;   // s in [0, 2^24]
    localparam int Q_FRAC  = 24;
    localparam int P_FRAC  = 16;
    localparam int MA_W    = 36;   // multiplier operand A
    localparam int MB_W    = 32;   // multiplier operand B
    localparam int P_W     = MA_W + MB_W;
    localparam int T_W     = 40;   // Horner partial values
    localparam int ACC_W   = 52;   // dot-product accumulators
    localparam int DQ_W    = 56;   // quotient magnitude
    localparam int X_W     = 58;   // estimate after a step
    localparam int S_ONE   = 16777216;
    localparam int START_EPS = 17;

    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_QUERY = 1'b1;

    localparam logic [1:0] ROW_A = 2'd0;
    localparam logic [1:0] ROW_B = 2'd1;
    localparam logic [1:0] ROW_C = 2'd2;
    localparam logic [1:0] ROW_D = 2'd3;

    // datapath micro-ops, issued in this order per axis
    typedef enum logic [3:0] {
        UOP_AS,     // t = a*s + b
        UOP_TSC,    // t = t*s + c
        UOP_TSD,    // p = t*s + d, diff = y - p
        UOP_A3S,    // t = 3a*s + 2b
        UOP_T2S,    // dp = t*s + c
        UOP_A6S,    // ddp = 6a*s + 2b
        UOP_DF,     // sum_f += diff*dp
        UOP_DD,     // sum_fd -= dp*dp
        UOP_DDD     // sum_fd += diff*ddp
    } uop_t;

    typedef struct packed {
        logic       wr_en;
        logic       cap_point;
        logic       start_first;
        logic       start_next;
        logic       start_init;
        logic       rd_en;
        logic [1:0] rd_row;
        logic [1:0] axis;
        logic       mul_en;
        logic       post_en;
        uop_t       uop;
        logic       clr_sum;
        logic       fin;
        logic       div_start;
        logic       x_upd;
        logic       res_load;
        logic       res_found;
    } dp_cmd_t;

    typedef struct packed {
        logic fd_zero;
        logic x_out;
        logic accept_ok;
        logic div_done;
    } dp_sts_t;

    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7fffffff);
        lo = ACC_W'(32'sh80000000);
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[FIX_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/scpn_div.sv
module scpn_div
    import scpn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [FIX_W-1:0]  num_in,
    input  logic signed [FIX_W-1:0]  den_in,
    output logic signed [DQ_W:0]     quot,
    output logic                     done
);
    // (num * 2^24) / den, truncated toward zero; one quotient bit per cycle

    localparam int CNT_W = $clog2(DQ_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DQ_W-1:0]   num_reg;
    logic [FIX_W:0]    rem_reg;
    logic [FIX_W-1:0]  den_reg;
    logic              neg_reg;

    logic signed [FIX_W:0] n33;
    logic signed [FIX_W:0] d33;
    logic [FIX_W:0]        n_abs;
    logic [FIX_W:0]        d_abs;
    logic [FIX_W:0]        rem_sh;
    logic [FIX_W:0]        rem_sub;
    logic                  qbit;

    always_comb
    begin
        n33 = (FIX_W+1)'(num_in);
        d33 = (FIX_W+1)'(den_in);
        n_abs = (n33 < 0) ? 33'(-n33) : 33'(n33);
        d_abs = (d33 < 0) ? 33'(-d33) : 33'(d33);
        rem_sh = {rem_reg[FIX_W-1:0], num_reg[DQ_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        qbit = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DQ_W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {n_abs[FIX_W-1:0], {Q_FRAC{1'b0}}};
            den_reg <= d_abs[FIX_W-1:0];
            rem_reg <= '0;
            neg_reg <= num_in[FIX_W-1] ^ den_in[FIX_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? rem_sub : rem_sh;
            num_reg <= {num_reg[DQ_W-2:0], qbit};
        end
    end

    assign quot = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
    assign done = done_reg;

endmodule

FILE: hw/rtl/scpn_dp.sv
module scpn_dp
    import scpn_pkg::*;
#(
    parameter int START_COUNT = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts,
    input  logic [IDX_W-1:0]         coeff_index,
    input  logic signed [FIX_W-1:0]  coeff_value,
    input  logic signed [FIX_W-1:0]  point_x,
    input  logic signed [FIX_W-1:0]  point_y,
    input  logic signed [FIX_W-1:0]  point_z,
    input  logic                     cfg_write_en,
    input  logic [TOL_W-1:0]         cfg_write_data,
    output logic                     found,
    output logic [PARAM_W-1:0]       curve_param
);

    localparam int SPAN = (START_COUNT > 1) ? (S_ONE / (START_COUNT - 1)) - START_EPS : 0;
    localparam logic signed [X_W-1:0] X_ONE = X_W'(S_ONE);

    logic signed [FIX_W-1:0] coef_mem [COEF_N];
    logic signed [FIX_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;
    logic [1:0]              rd_row_reg;
    logic signed [FIX_W-1:0] coef_reg [ROWS];
    logic signed [FIX_W-1:0] y_reg [AXES];

    logic [TOL_W-1:0]        tol_reg;
    logic [S_W-1:0]          x_start_reg;
    logic signed [X_W-1:0]   x_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [FIX_W-1:0] diff_reg;
    logic signed [FIX_W-1:0] dp_reg;
    logic signed [FIX_W-1:0] ddp_reg;
    logic signed [ACC_W-1:0] sum_f_reg;
    logic signed [ACC_W-1:0] sum_fd_reg;
    logic signed [FIX_W-1:0] f_reg;
    logic signed [FIX_W-1:0] fd_reg;
    logic                    found_reg;
    logic [PARAM_W-1:0]      param_reg;

    logic [IDX_W-1:0]        rd_addr;
    logic signed [MA_W-1:0]  a36;
    logic signed [MA_W-1:0]  a3;
    logic signed [MA_W-1:0]  a6;
    logic signed [T_W-1:0]   b2;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MB_W-1:0]  s_op;
    logic signed [P_W-1:0]   sh24_full;
    logic signed [P_W-1:0]   sh16_full;
    logic signed [T_W-1:0]   sh24;
    logic signed [ACC_W-1:0] sh16;
    logic signed [T_W-1:0]   addend;
    logic signed [T_W-1:0]   pv;
    logic signed [FIX_W-1:0] pv_sat;
    logic signed [FIX_W-1:0] y_sel;
    logic signed [FIX_W-1:0] diff_new;
    logic signed [DQ_W:0]    quot;
    logic                    div_done;
    logic signed [FIX_W:0]   f33;
    logic signed [FIX_W:0]   abs_f;

    scpn_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num_in (f_reg),
        .den_in (fd_reg),
        .quot   (quot),
        .done   (div_done)
    );

    always_comb
    begin
        rd_addr = ({2'b00, cmd.rd_row} << 1) + {2'b00, cmd.rd_row} + {2'b00, cmd.axis};
        a36 = MA_W'(coef_reg[ROW_A]);
        a3 = a36 + (a36 <<< 1);
        a6 = a3 <<< 1;
        b2 = T_W'(coef_reg[ROW_B]) <<< 1;
        s_op = $signed({{(MB_W-S_W){1'b0}}, x_reg[S_W-1:0]});
        y_sel = y_reg[0];
        case (cmd.axis)
            2'd1:    y_sel = y_reg[1];
            2'd2:    y_sel = y_reg[2];
            default: y_sel = y_reg[0];
        endcase

        mul_a = a36;
        mul_b = s_op;
        addend = T_W'(coef_reg[ROW_B]);
        case (cmd.uop)
            UOP_AS:
            begin
                mul_a = a36;
                addend = T_W'(coef_reg[ROW_B]);
            end
            UOP_TSC:
            begin
                mul_a = t_reg[MA_W-1:0];
                addend = T_W'(coef_reg[ROW_C]);
            end
            UOP_TSD:
            begin
                mul_a = t_reg[MA_W-1:0];
                addend = T_W'(coef_reg[ROW_D]);
            end
            UOP_A3S:
            begin
                mul_a = a3;
                addend = b2;
            end
            UOP_T2S:
            begin
                mul_a = t_reg[MA_W-1:0];
                addend = T_W'(coef_reg[ROW_C]);
            end
            UOP_A6S:
            begin
                mul_a = a6;
                addend = b2;
            end
            UOP_DF:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = dp_reg;
            end
            UOP_DD:
            begin
                mul_a = MA_W'(dp_reg);
                mul_b = dp_reg;
            end
            UOP_DDD:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = ddp_reg;
            end
            default:
            begin
                mul_a = a36;
            end
        endcase

        // arithmetic shifts floor toward minus infinity
        sh24_full = prod_reg >>> Q_FRAC;
        sh16_full = prod_reg >>> P_FRAC;
        sh24 = $signed(sh24_full[T_W-1:0]);
        sh16 = $signed(sh16_full[ACC_W-1:0]);
        pv = sh24 + addend;
        pv_sat = sat32(ACC_W'(pv));
        diff_new = sat32(ACC_W'(y_sel) - ACC_W'(pv_sat));

        f33 = (FIX_W+1)'(f_reg);
        abs_f = (f33 < 0) ? -f33 : f33;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_W'(1);
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            param_reg  <= '0;
        end
        else
        begin
            if (cfg_write_en)
                tol_reg <= cfg_write_data;
            rd_vld_reg <= cmd.rd_en;
            if (cmd.res_load)
            begin
                found_reg <= cmd.res_found;
                param_reg <= cmd.res_found ? x_reg[PARAM_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (coeff_index < IDX_W'(COEF_N)))
            coef_mem[coeff_index] <= coeff_value;
        rd_data_reg <= coef_mem[rd_addr];
        rd_row_reg  <= cmd.rd_row;
        if (rd_vld_reg)
            coef_reg[rd_row_reg] <= rd_data_reg;

        if (cmd.cap_point)
        begin
            y_reg[0] <= point_x;
            y_reg[1] <= point_y;
            y_reg[2] <= point_z;
        end

        if (cmd.start_first)
            x_start_reg <= S_W'(START_EPS);
        else if (cmd.start_next)
            x_start_reg <= x_start_reg + S_W'(SPAN);

        if (cmd.start_init)
            x_reg <= X_W'(x_start_reg);
        else if (cmd.x_upd)
            x_reg <= x_reg - X_W'(quot);

        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;

        if (cmd.clr_sum)
        begin
            sum_f_reg  <= '0;
            sum_fd_reg <= '0;
        end
        else if (cmd.post_en)
        begin
            case (cmd.uop)
                UOP_AS:  t_reg <= pv;
                UOP_TSC: t_reg <= pv;
                UOP_TSD: diff_reg <= diff_new;
                UOP_A3S: t_reg <= pv;
                UOP_T2S: dp_reg <= pv_sat;
                UOP_A6S: ddp_reg <= pv_sat;
                UOP_DF:  sum_f_reg <= sum_f_reg + sh16;
                UOP_DD:  sum_fd_reg <= sum_fd_reg - sh16;
                UOP_DDD: sum_fd_reg <= sum_fd_reg + sh16;
                default: t_reg <= pv;
            endcase
        end

        if (cmd.fin)
        begin
            f_reg  <= sat32(sum_f_reg);
            fd_reg <= sat32(sum_fd_reg);
        end
    end

    always_comb
    begin
        sts.fd_zero   = (fd_reg == '0);
        sts.x_out     = (x_reg < 0) || (x_reg > X_ONE);
        sts.accept_ok = (abs_f < $signed({{(FIX_W+1-TOL_W){1'b0}}, tol_reg}))
                        && (x_reg > 0) && (x_reg < X_ONE);
        sts.div_done  = div_done;
    end

    assign found       = found_reg;
    assign curve_param = param_reg;

endmodule

FILE: hw/rtl/scpn_ctrl.sv
module scpn_ctrl
    import scpn_pkg::*;
#(
    parameter int NEWTON_STEPS = 4,
    parameter int START_COUNT  = 3
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    opcode,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam int SW = $clog2(NEWTON_STEPS + 1);
    localparam int KW = $clog2(START_COUNT + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_CLR, S_RD, S_MUL, S_POST, S_FIN, S_CHK,
        S_DIVW, S_UPD, S_STEP, S_ACC, S_NEXT, S_RES
    } state_t;

    state_t        state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [KW-1:0] start_reg, start_next;
    logic [1:0]    axis_reg, axis_next;
    logic [2:0]    rd_cnt_reg, rd_cnt_next;
    uop_t          uop_reg, uop_next;
    logic          found_reg, found_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        start_next     = start_reg;
        axis_next      = axis_reg;
        rd_cnt_next    = rd_cnt_reg;
        uop_next       = uop_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && out_stall;
        accept         = in_valid && (state_reg == S_IDLE);

        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.uop       = uop_reg;
        cmd.rd_row    = rd_cnt_reg[1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OPC_LOAD)
                        cmd.wr_en = 1'b1;
                    else
                    begin
                        cmd.cap_point   = 1'b1;
                        cmd.start_first = 1'b1;
                        start_next      = '0;
                        state_next      = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.start_init = 1'b1;
                step_next      = '0;
                state_next     = S_CLR;
            end
            S_CLR:
            begin
                cmd.clr_sum = 1'b1;
                axis_next   = '0;
                rd_cnt_next = '0;
                state_next  = S_RD;
            end
            S_RD:
            begin
                cmd.rd_en = !rd_cnt_reg[2];
                if (rd_cnt_reg[2])
                begin
                    uop_next   = UOP_AS;
                    state_next = S_MUL;
                end
                else
                    rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                cmd.post_en = 1'b1;
                if (uop_reg == UOP_DDD)
                begin
                    if (axis_reg == 2'(AXES - 1))
                        state_next = S_FIN;
                    else
                    begin
                        axis_next   = axis_reg + 1'b1;
                        rd_cnt_next = '0;
                        state_next  = S_RD;
                    end
                end
                else
                begin
                    uop_next   = uop_t'(uop_reg + 1'b1);
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.fd_zero)
                    state_next = S_NEXT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (sts.div_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.x_upd  = 1'b1;
                step_next  = step_reg + 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.x_out || (step_reg == SW'(NEWTON_STEPS)))
                    state_next = S_ACC;
                else
                    state_next = S_CLR;
            end
            S_ACC:
            begin
                if (sts.accept_ok)
                begin
                    found_next = 1'b1;
                    state_next = S_RES;
                end
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (start_reg == KW'(START_COUNT - 1))
                begin
                    found_next = 1'b0;
                    state_next = S_RES;
                end
                else
                begin
                    cmd.start_next = 1'b1;
                    start_next     = start_reg + 1'b1;
                    state_next     = S_START;
                end
            end
            S_RES:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_found  = found_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            start_reg     <= '0;
            axis_reg      <= '0;
            rd_cnt_reg    <= '0;
            uop_reg       <= UOP_AS;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            start_reg     <= start_next;
            axis_reg      <= axis_next;
            rd_cnt_reg    <= rd_cnt_next;
            uop_reg       <= uop_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/spline_closest_point_newton_top.sv
// Closest-point search on one cubic 3-D curve segment (Newton, Q16.16).
//
// Input channel (in_valid / in_stall): one word is either a coefficient load
// (opcode 0: coeff_index, coeff_value) or a query (opcode 1: point_x/y/z).
// A load gives no result word; loads past index 11 are
// dropped. Every query gives exactly one result word (found, curve_param).
// Output channel (out_valid / out_stall): the result sits in an output
// register; the next word is accepted while it still waits to be taken.
// A query only writes its result once the previous one has left, so a
// stalled receiver holds the block in its final state, never losing a word.
// Each Newton step covers 3 axes, each with 4 coefficient reads and 9
// multiply/accumulate ops (a multiply, then a post step), followed by the
// bit-serial divider and the control states. A query takes up to
// START_COUNT x NEWTON_STEPS steps; one query is processed at a time, set
// by the shared multiplier and divider.
// cfg_write_en / cfg_write_data write the residual tolerance (reset value 1).
// Reset clears control and sets the tolerance to 1; coefficients are
// undefined until loaded.
module spline_closest_point_newton_top
    import scpn_pkg::*;
#(
    parameter int NEWTON_STEPS = 4,
    parameter int START_COUNT  = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [IDX_W-1:0]         coeff_index,
    input  logic signed [FIX_W-1:0]  coeff_value,
    input  logic signed [FIX_W-1:0]  point_x,
    input  logic signed [FIX_W-1:0]  point_y,
    input  logic signed [FIX_W-1:0]  point_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic [PARAM_W-1:0]       curve_param,
    input  logic                     cfg_write_en,
    input  logic [TOL_W-1:0]         cfg_write_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: starts, steps, per-axis micro-op order, result handshake
    scpn_ctrl #(
        .NEWTON_STEPS (NEWTON_STEPS),
        .START_COUNT  (START_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // coefficient store, shared multiplier, accumulators, divider, estimate
    scpn_dp #(
        .START_COUNT (START_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .coeff_index    (coeff_index),
        .coeff_value    (coeff_value),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .found          (found),
        .curve_param    (curve_param)
    );

endmodule

FILE: tb/tb_spline_closest_point_newton_top.sv
module tb_spline_closest_point_newton_top;
    import scpn_pkg::*;

    // Search depth of the block as instantiated (its defaults).
    localparam int N_STEPS    = 4;
    localparam int N_STARTS   = 3;
    localparam longint Q24_ONE = 64'sd16777216;
    localparam int EPS_START  = 17;
    // Run limit: the worst-case query time plus stalls, many times over.
    localparam int CYCLE_LIMIT = 6000000;
    // Long receiver hold-off, several queries long.
    localparam int LONG_HOLD  = 6000;

    // One input word as the sender queues it.
    typedef struct {
        logic                    op;
        logic [IDX_W-1:0]        idx;
        logic signed [FIX_W-1:0] val;
        logic signed [FIX_W-1:0] px;
        logic signed [FIX_W-1:0] py;
        logic signed [FIX_W-1:0] pz;
    } word_t;

    // One projection result.
    typedef struct {
        logic               hit;
        logic [PARAM_W-1:0] s;
    } proj_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    opcode = OPC_LOAD;
    logic [IDX_W-1:0]        coeff_index = '0;
    logic signed [FIX_W-1:0] coeff_value = '0;
    logic signed [FIX_W-1:0] point_x = '0;
    logic signed [FIX_W-1:0] point_y = '0;
    logic signed [FIX_W-1:0] point_z = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    found;
    logic [PARAM_W-1:0]      curve_param;
    logic                    cfg_write_en = 1'b0;
    logic [TOL_W-1:0]        cfg_write_data = '0;

    word_t  pending_words[$];
    proj_t  expected_proj[$];
    word_t  shown_word;

    // Shadow of the segment, updated as words are accepted, and of the tolerance.
    logic signed [FIX_W-1:0] coef_shadow[COEF_N];
    logic [TOL_W-1:0]        tol_shadow = 16'd1;

    // Generator-side copy of the curve, used to place points near it.
    logic signed [FIX_W-1:0] gen_coef[COEF_N];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_count = 0;
    logic idle_on = 1'b1;
    logic hold_long = 1'b0;

    always #10 clk = ~clk;

    spline_closest_point_newton_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .coeff_index    (coeff_index),
        .coeff_value    (coeff_value),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .curve_param    (curve_param),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Residual f and its slope at parameter s (Q0.24), per-axis Horner form.
    function automatic void residual_at(input longint yx, input longint yy, input longint yz,
                                        input longint s, output longint f, output longint fd);
        longint y[3];
        longint a, b, c, d, t, p, dp, ddp, diff;
        longint acc_f, acc_fd;
        y[0] = yx;
        y[1] = yy;
        y[2] = yz;
        acc_f = 0;
        acc_fd = 0;
        for (int ax = 0; ax < AXES; ax++)
        begin
            a = coef_shadow[ax];
            b = coef_shadow[3 + ax];
            c = coef_shadow[6 + ax];
            d = coef_shadow[9 + ax];
            t = ((a * s) >>> 24) + b;
            t = ((t * s) >>> 24) + c;
            p = clamp32(((t * s) >>> 24) + d);
            t = ((3 * a * s) >>> 24) + 2 * b;
            dp = clamp32(((t * s) >>> 24) + c);
            ddp = clamp32(((6 * a * s) >>> 24) + 2 * b);
            diff = clamp32(y[ax] - p);
            acc_f += (diff * dp) >>> 16;
            acc_fd -= (dp * dp) >>> 16;
            acc_fd += (diff * ddp) >>> 16;
        end
        f = clamp32(acc_f);
        fd = clamp32(acc_fd);
    endfunction

    // Newton search over the starts; the first accepted start wins.
    function automatic proj_t project_point(input word_t w);
        proj_t  r;
        longint span, x, f, fd;
        logic   dropped;
        span = (N_STARTS > 1) ? (Q24_ONE / (N_STARTS - 1)) - EPS_START : 0;
        r.hit = 1'b0;
        r.s = '0;
        for (int k = 0; k < N_STARTS; k++)
        begin
            x = EPS_START + k * span;
            f = 0;
            fd = 0;
            dropped = 1'b0;
            for (int i = 0; i < N_STEPS; i++)
            begin
                residual_at(w.px, w.py, w.pz, x, f, fd);
                if (fd == 0)
                begin
                    dropped = 1'b1;
                    break;
                end
                x = x - (f * Q24_ONE) / fd;
                if (x < 0 || x > Q24_ONE)
                    break;
            end
            if (!dropped && ((f < 0) ? -f : f) < longint'(tol_shadow)
                && x > 0 && x < Q24_ONE)
            begin
                r.hit = 1'b1;
                r.s = x[PARAM_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    // Sender: presents queued words, holds them while stalled, inserts gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (shown_word.op == OPC_QUERY)
                    expected_proj = {expected_proj, project_point(shown_word)};
                else if (shown_word.idx < COEF_N)
                    coef_shadow[shown_word.idx] = shown_word.val;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    shown_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    opcode <= shown_word.op;
                    coeff_index <= shown_word.idx;
                    coeff_value <= shown_word.val;
                    point_x <= shown_word.px;
                    point_y <= shown_word.py;
                    point_z <= shown_word.pz;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 19);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_long && hold_count < LONG_HOLD)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else if (recv_gap > 0)
        begin
            out_stall <= 1'b1;
            recv_gap <= recv_gap - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            recv_gap <= $urandom_range(0, 18);
        end
        else
            out_stall <= 1'b0;
    end

    // Result checker: each word taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        proj_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_proj.size() == 0)
            begin
                $error("unexpected result word: found %0d curve_param %0h",
                       found, curve_param);
                fail_count++;
            end
            else
            begin
                want = expected_proj.pop_front();
                if (found !== want.hit)
                begin
                    $error("found mismatch: expected %0d actual %0d", want.hit, found);
                    fail_count++;
                end
                if (curve_param !== want.s)
                begin
                    $error("curve_param mismatch: expected %0h actual %0h",
                           want.s, curve_param);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_load(input int idx, input logic signed [FIX_W-1:0] v);
        word_t w;
        w.op = OPC_LOAD;
        w.idx = IDX_W'(idx);
        w.val = v;
        w.px = $urandom;
        w.py = $urandom;
        w.pz = $urandom;
        pending_words = {pending_words, w};
        if (idx < COEF_N)
            gen_coef[idx] = v;
    endtask

    task automatic push_query(input logic signed [FIX_W-1:0] x, input logic signed [FIX_W-1:0] y,
                              input logic signed [FIX_W-1:0] z);
        word_t w;
        w.op = OPC_QUERY;
        w.idx = $urandom;
        w.val = $urandom;
        w.px = x;
        w.py = y;
        w.pz = z;
        pending_words = {pending_words, w};
    endtask

    // Signed value with magnitude up to lim (Q16.16 raw).
    function automatic logic signed [FIX_W-1:0] rand_mag(input int unsigned lim);
        int v;
        v = $urandom_range(0, lim);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    // Point on the current generator curve at s, plus noise.
    task automatic push_near_query(input real s, input int unsigned noise);
        real    c[COEF_N];
        longint q[AXES];
        for (int i = 0; i < COEF_N; i++)
            c[i] = $itor(gen_coef[i]) / 65536.0;
        for (int ax = 0; ax < AXES; ax++)
            q[ax] = clamp32($rtoi((((c[ax] * s + c[3 + ax]) * s + c[6 + ax]) * s + c[9 + ax])
                    * 65536.0) + rand_mag(noise));
        push_query(q[0][31:0], q[1][31:0], q[2][31:0]);
    endtask

    // A whole new segment, usually tame, sometimes full-range noise.
    task automatic push_segment();
        logic wild;
        wild = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < COEF_N; i++)
        begin
            if (wild)
                push_load(i, $urandom);
            else if (i >= 9)
                push_load(i, rand_mag(32'd8 << 16));
            else
                push_load(i, rand_mag(32'd4 << 16));
        end
    endtask

    task automatic random_words(input int n);
        int sent;
        int kind;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 3)
            begin
                push_segment();
                sent += COEF_N;
            end
            else if (kind == 3)
            begin
                push_load($urandom_range(0, 11), $urandom);
                sent++;
            end
            else if (kind == 4)
                push_load($urandom_range(12, 15), $urandom);   // dropped by the block
            else if (kind < 7)
            begin
                push_query($urandom, $urandom, $urandom);
                sent++;
            end
            else
            begin
                push_near_query($itor($urandom_range(0, 1000)) / 1000.0,
                                (kind < 14) ? 2000 : 40000);
                sent++;
            end
        end
    endtask

    // Wait until the sender is empty and every prediction has been met.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_proj.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        tol_shadow = v;
    endtask

    initial
    begin
        for (int i = 0; i < COEF_N; i++)
        begin
            coef_shadow[i] = '0;
            gen_coef[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset tolerance. A straight line first.
        for (int i = 0; i < 6; i++)
            push_load(i, '0);
        push_load(6, 32'sd4 << 16);
        push_load(7, 32'sd2 << 16);
        push_load(8, 32'sd1 << 16);
        push_load(9, -32'sd1 << 16);
        push_load(10, '0);
        push_load(11, 32'sd3 << 16);
        push_near_query(0.3, 0);                          // point on the line
        push_near_query(1.5, 0);                          // estimate leaves range
        push_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        push_query(32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_query('0, '0, '0);
        push_load(13, 32'sh7fffffff);                     // index out of range
        push_load(15, 32'sh80000000);
        push_load(0, 32'sh7fffffff);                      // saturating cubic
        push_load(4, 32'sh80000000);
        push_query(32'sh12345678, 32'sh80000000, 32'sh7fffffff);
        drain();

        // Flat curve: zero slope everywhere, every start abandoned; then random words.
        set_tolerance(16'hffff);
        for (int i = 0; i < COEF_N; i++)
            push_load(i, '0);
        push_query(32'sh00010000, '0, '0);
        push_query('0, '0, '0);
        push_segment();
        random_words(200);
        drain();

        // Zero tolerance: nothing can be accepted.
        set_tolerance(16'h0000);
        random_words(100);
        drain();

        // Long receiver hold-off: the block fills and stalls its input.
        set_tolerance(16'd3000);
        hold_long <= 1'b1;
        random_words(100);
        drain();

        set_tolerance(16'($urandom));
        random_words(200);
        drain();

        // Last part: no idling on either side.
        idle_on <= 1'b0;
        set_tolerance(16'hffff);
        random_words(200);
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
